@@ src/spd_pkg.sv @@
// Shared types, codes and helper functions for the serial packet deframer.
// No dependencies; used by serial_packet_deframer_core.
`timescale 1ns / 1ps
`default_nettype none

package spd_pkg;

    // Register indexes of the configuration port
    localparam logic [1:0] CFG_FRAME_FIRST  = 2'd0;
    localparam logic [1:0] CFG_FRAME_SECOND = 2'd1;
    localparam logic [1:0] CFG_MAX_BODY     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0] FRAME_FIRST_RST  = 8'h00;
    localparam logic [7:0] FRAME_SECOND_RST = 8'h00;
    localparam logic [7:0] MAX_BODY_RST     = 8'hff;

    // Hang-up pattern: CR LF "NO CARRIER" CR LF
    localparam logic [3:0] PATTERN_LEN = 4'd14;

    // CRC-16 generator and top bit
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // Result queue depth (one item can yield up to three results)
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        KIND_BODY    = 2'd0,
        KIND_END     = 2'd1,
        KIND_CARRIER = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_GOOD     = 2'd0,
        ST_CRC_BAD  = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] body_byte;
        t_status    end_status;
        logic       last;
    } t_result;

    // Pattern byte at a given match position
    function automatic logic [7:0] hangup_byte(input logic [3:0] idx);
        logic [7:0] v;
        unique case (idx)
            4'd0:    v = 8'h0d;
            4'd1:    v = 8'h0a;
            4'd2:    v = 8'h4e;
            4'd3:    v = 8'h4f;
            4'd4:    v = 8'h20;
            4'd5:    v = 8'h43;
            4'd6:    v = 8'h41;
            4'd7:    v = 8'h52;
            4'd8:    v = 8'h52;
            4'd9:    v = 8'h49;
            4'd10:   v = 8'h45;
            4'd11:   v = 8'h52;
            4'd12:   v = 8'h0d;
            4'd13:   v = 8'h0a;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // One byte of CRC-16, MSB first, unrolled over eight bit steps
    function automatic logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] a;
        a = acc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((a & CRC_TOP) != 16'h0000) begin
                a = {a[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                a = {a[14:0], 1'b0};
            end
        end
        return a;
    endfunction

endpackage

`default_nettype wire

@@ src/serial_packet_deframer_core.sv @@
// Serial packet deframer with hang-up pattern matcher, top level.
// Depends on spd_pkg for result types, codes, the pattern table and CRC step.
//
// Usage:
//   Slave stream: one received serial byte per item on i_s_axis_tdata.
//   Master stream: results, one per item; tuser carries the kind (body byte,
//   packet end status, carrier lost), tdata the body byte and end status,
//   tlast marks the final result caused by one input byte.
//   Config channel: i_cfg_index selects frame byte one, frame byte two or the
//   body length limit; writes are taken in every cycle (o_cfg_ready is high)
//   and belong only to times when no item is in flight.
// Results of an accepted byte are written into the result queue and driven from its head.
// Throughput: one byte per cycle while each byte yields at most one result and
//   the receiver keeps tready high; the four-entry result queue drains one per
//   cycle, so a byte yielding two or three results holds off the following bytes.
// Reset: synchronous, active low; clears the hunt, CRC and matcher state,
//   empties the result queue and loads the register reset values.
// Stall: while the receiver holds tready low the queue holds its entries and
//   o_s_axis_tready drops once fewer than three free entries remain.
`timescale 1ns / 1ps
`default_nettype none

module serial_packet_deframer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [7:0] body_byte, [9:8] end_status, rest 0
    output logic [1:0]       o_m_axis_tuser,   // [1:0] kind
    output logic             o_m_axis_tlast,
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    localparam int unsigned AW = spd_pkg::QUEUE_AW;
    localparam int unsigned CW = AW + 1;

    // configuration registers
    logic [7:0] r_frame_first;
    logic [7:0] r_frame_second;
    logic [7:0] r_max_len;

    // deframer and matcher state
    logic [8:0]  r_byte_count, n_byte_count;
    logic [7:0]  r_body_length, n_body_length;
    logic [7:0]  r_expected_crc, n_expected_crc;
    logic [15:0] r_crc, n_crc;
    logic [3:0]  r_match_pos, n_match_pos;

    // result queue
    spd_pkg::t_result        r_queue [spd_pkg::QUEUE_DEPTH];
    logic [AW-1:0]           r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]           r_count;

    logic                    in_fire, out_fire;
    logic [7:0]              rx;
    logic                    carrier_hit, body_emit, end_emit;
    spd_pkg::t_status        end_st;
    spd_pkg::t_result        res [3];
    logic [1:0]              push_n;
    logic [3:0]              pos;
    logic [8:0]              cnt;
    logic [7:0]              hdr_sum;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_count <= CW'(spd_pkg::QUEUE_DEPTH - 3));
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign out_fire        = o_m_axis_tvalid && i_m_axis_tready;
    assign rx              = i_s_axis_tdata;
    assign hdr_sum         = r_frame_first + r_frame_second + r_body_length;

    // hang-up pattern matcher
    always_comb begin
        pos         = (r_match_pos >= spd_pkg::PATTERN_LEN) ? 4'd0 : r_match_pos;
        carrier_hit = 1'b0;
        n_match_pos = 4'd0;
        if (rx == spd_pkg::hangup_byte(pos)) begin
            if (pos + 4'd1 == spd_pkg::PATTERN_LEN) begin
                carrier_hit = 1'b1;
            end else begin
                n_match_pos = pos + 4'd1;
            end
        end else if (pos != 4'd0 && rx == spd_pkg::hangup_byte(4'd0)) begin
            n_match_pos = 4'd1;
        end
    end

    // packet deframer: header hunt, CRC and end status
    always_comb begin
        cnt            = r_byte_count + 9'd1;
        n_body_length  = r_body_length;
        n_expected_crc = r_expected_crc;
        n_crc          = r_crc;
        body_emit      = 1'b0;
        end_emit       = 1'b0;
        end_st         = spd_pkg::ST_GOOD;
        priority if (cnt == 9'd1) begin
            if (rx != r_frame_first) cnt = 9'd0;
        end else if (cnt == 9'd2) begin
            if (rx != r_frame_second) cnt = 9'd0;
        end else if (cnt == 9'd3) begin
            n_body_length = rx;
        end else if (cnt == 9'd4) begin
            if (rx != hdr_sum) cnt = 9'd0;
        end else begin
            if (cnt == 9'd5) begin
                n_expected_crc = rx;
                n_crc          = 16'h0000;
            end else begin
                n_crc     = spd_pkg::crc_update(r_crc, rx);
                body_emit = (r_body_length <= r_max_len);
            end
            if (cnt >= 9'd5 + {1'b0, r_body_length}) begin
                end_emit = 1'b1;
                if (n_crc[7:0] != n_expected_crc) begin
                    end_st = spd_pkg::ST_CRC_BAD;
                end else if (r_body_length > r_max_len) begin
                    end_st = spd_pkg::ST_TOO_LONG;
                end
                cnt = 9'd0;
            end
        end
        n_byte_count = cnt;
    end

    // order the results of this byte: carrier lost, body byte, end status
    always_comb begin
        spd_pkg::t_result cand [3];
        logic [2:0]       want;
        cand[0] = '{kind: spd_pkg::KIND_CARRIER, body_byte: 8'h00,
                    end_status: spd_pkg::ST_GOOD, last: 1'b0};
        cand[1] = '{kind: spd_pkg::KIND_BODY, body_byte: rx,
                    end_status: spd_pkg::ST_GOOD, last: 1'b0};
        cand[2] = '{kind: spd_pkg::KIND_END, body_byte: 8'h00,
                    end_status: end_st, last: 1'b0};
        want    = {end_emit, body_emit, carrier_hit};
        push_n  = 2'd0;
        for (int k = 0; k < 3; k++) begin
            res[k] = cand[2];
        end
        for (int k = 0; k < 3; k++) begin
            if (want[k]) begin
                res[push_n] = cand[k];
                push_n      = push_n + 2'd1;
            end
        end
        // mark the final result of this byte
        for (int k = 0; k < 3; k++) begin
            res[k].last = (2'(k) + 2'd1 == push_n);
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_first  <= spd_pkg::FRAME_FIRST_RST;
            r_frame_second <= spd_pkg::FRAME_SECOND_RST;
            r_max_len      <= spd_pkg::MAX_BODY_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                spd_pkg::CFG_FRAME_FIRST:  r_frame_first  <= i_cfg_data;
                spd_pkg::CFG_FRAME_SECOND: r_frame_second <= i_cfg_data;
                spd_pkg::CFG_MAX_BODY:     r_max_len      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance deframer and matcher state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= 9'd0;
            r_body_length  <= 8'd0;
            r_expected_crc <= 8'd0;
            r_crc          <= 16'h0000;
            r_match_pos    <= 4'd0;
        end else if (in_fire) begin
            r_byte_count   <= n_byte_count;
            r_body_length  <= n_body_length;
            r_expected_crc <= n_expected_crc;
            r_crc          <= n_crc;
            r_match_pos    <= n_match_pos;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            for (int k = 0; k < 3; k++) begin
                if (2'(k) < push_n) begin
                    r_queue[r_wr_ptr + AW'(k)] <= res[k];
                end
            end
        end
    end

    // result queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_fire) begin
                r_wr_ptr <= r_wr_ptr + AW'(push_n);
            end
            if (out_fire) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count <= r_count + (in_fire ? CW'(push_n) : CW'(0)) - (out_fire ? CW'(1) : CW'(0));
        end
    end

    // drive the result stream from the queue head
    assign o_m_axis_tvalid = (r_count != '0);
    assign o_m_axis_tdata  = {6'b000000, r_queue[r_rd_ptr].end_status,
                              r_queue[r_rd_ptr].body_byte};
    assign o_m_axis_tuser  = r_queue[r_rd_ptr].kind;
    assign o_m_axis_tlast  = r_queue[r_rd_ptr].last;

endmodule

`default_nettype wire

@@ bench/serial_packet_deframer_core_tb.sv @@
// Self-checking bench for serial_packet_deframer_core: framed packets, broken headers,
// noise and hang-up patterns go in; each result is checked against a built-in predictor or a typed row.
// Depends on spd_pkg and serial_packet_deframer_core.
`timescale 1ns / 1ps

module serial_packet_deframer_core_tb;

    import spd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;

    // CR LF "NO CARRIER" CR LF, first byte at index 0
    localparam logic [0:13][7:0] HANGUP_SEQ = {
        8'h0d, 8'h0a, 8'h4e, 8'h4f, 8'h20, 8'h43, 8'h41,
        8'h52, 8'h52, 8'h49, 8'h45, 8'h52, 8'h0d, 8'h0a
    };

    localparam t_result NO_RESULT = '0;

    // How a stimulus row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_TYPED
    } t_chk;

    // Receiver stall modes
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_COMB
    } t_rx_mode;

    typedef struct packed {
        logic [7:0] rx;
        t_chk       mode;
        t_result    want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        o_m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    // Predictor copy of the registers and the deframer state
    logic [7:0]  frame_a;
    logic [7:0]  frame_b;
    logic [7:0]  body_limit;
    int          hdr_count;
    logic [7:0]  pkt_len;
    logic [7:0]  pkt_crc;
    logic [15:0] crc_run;
    logic [3:0]  hangup_pos;

    t_result     step_res [3];
    t_result     pending_results [$];
    t_stim_row   dir_rows [$];

    int          err_count   = 0;
    int          cycle_count = 0;
    int          sent_count  = 0;
    int          burst_left  = 0;
    bit          idle_on     = 1'b1;
    t_rx_mode    rx_mode     = RX_OPEN;
    int          rx_span     = 0;
    logic [7:0]  rx_tick     = '0;

    serial_packet_deframer_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Bit-serial CRC-16, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0};
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic t_result result_of(input t_kind k, input logic [7:0] b,
                                          input t_status st);
        t_result r;
        r.kind       = k;
        r.body_byte  = b;
        r.end_status = st;
        r.last       = 1'b0;
        return r;
    endfunction

    // Advance the predicted state by one byte; results land in step_res
    function automatic int deframe_byte(input logic [7:0] b);
        int         n;
        int         cnt;
        logic [3:0] pos;
        logic [7:0] hsum;
        t_status    st;
        n   = 0;
        pos = (hangup_pos >= PATTERN_LEN) ? 4'd0 : hangup_pos;
        if (b == HANGUP_SEQ[pos]) begin
            pos = pos + 4'd1;
            if (pos == PATTERN_LEN) begin
                step_res[n] = result_of(KIND_CARRIER, 8'h00, ST_GOOD);
                n++;
                pos = 4'd0;
            end
        end else if (pos != 4'd0) begin
            pos = (b == HANGUP_SEQ[0]) ? 4'd1 : 4'd0;
        end
        hangup_pos = pos;

        cnt = hdr_count + 1;
        case (cnt)
            1: begin
                if (b != frame_a) cnt = 0;
            end
            2: begin
                if (b != frame_b) cnt = 0;
            end
            3: begin
                pkt_len = b;
            end
            4: begin
                hsum = frame_a + frame_b + pkt_len;
                if (b != hsum) cnt = 0;
            end
            default: begin
                if (cnt == 5) begin
                    pkt_crc = b;
                    crc_run = '0;
                end else begin
                    crc_run = crc16_byte(crc_run, b);
                    if (pkt_len <= body_limit) begin
                        step_res[n] = result_of(KIND_BODY, b, ST_GOOD);
                        n++;
                    end
                end
                if (cnt >= 5 + int'(pkt_len)) begin
                    // CRC fault outranks an over-long body
                    if (crc_run[7:0] != pkt_crc) st = ST_CRC_BAD;
                    else if (pkt_len > body_limit) st = ST_TOO_LONG;
                    else st = ST_GOOD;
                    step_res[n] = result_of(KIND_END, 8'h00, st);
                    n++;
                    cnt = 0;
                end
            end
        endcase
        hdr_count = cnt;
        if (n > 0) step_res[n-1].last = 1'b1;
        return n;
    endfunction

    task automatic add_row(input logic [7:0] rx, input t_chk mode, input t_kind k,
                           input t_status st);
        t_stim_row row;
        row.rx        = rx;
        row.mode      = mode;
        row.want      = result_of(k, 8'h00, st);
        row.want.last = 1'b1;
        dir_rows.push_back(row);
    endtask

    // Offer one byte, with sender bursts and gaps; predict once accepted
    task automatic send_byte(input logic [7:0] b, input t_chk mode, input t_result want);
        int gap;
        bit done;
        int n;
        @(negedge i_clk);
        if (burst_left == 0) begin
            if (idle_on) begin
                gap = $urandom_range(1, 6);
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        done = 1'b0;
        while (!done) begin
            @(posedge i_clk);
            done = o_s_axis_tready;
        end
        sent_count++;
        n = deframe_byte(b);
        case (mode)
            CHK_MODEL: begin
                for (int k = 0; k < n; k++) pending_results.push_back(step_res[k]);
            end
            CHK_TYPED: begin
                pending_results.push_back(want);
            end
            default: ;
        endcase
    endtask

    // Hold the input until every expected result has come, then let the block settle
    task automatic wait_drained;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        bit done;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        done = 1'b0;
        while (!done) begin
            @(posedge i_clk);
            done = o_cfg_ready;
        end
        case (idx)
            CFG_FRAME_FIRST:  frame_a    = val;
            CFG_FRAME_SECOND: frame_b    = val;
            CFG_MAX_BODY:     body_limit = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Send one packet, or a broken header, for the current frame bytes; optionally retune the limit mid-body
    task automatic send_packet(input int len, input bit crc_ok, input bit hdr_ok,
                               input int retune_at, input logic [7:0] retune_val);
        logic [7:0]  body [$];
        logic [15:0] acc;
        logic [7:0]  hsum;
        logic [7:0]  crc_b;
        acc = '0;
        for (int i = 0; i < len; i++) begin
            body.push_back(8'($urandom_range(0, 255)));
            acc = crc16_byte(acc, body[i]);
        end
        hsum  = frame_a + frame_b + len[7:0];
        crc_b = crc_ok ? acc[7:0] : acc[7:0] ^ 8'($urandom_range(1, 255));
        send_byte(frame_a, CHK_MODEL, NO_RESULT);
        if (!hdr_ok && $urandom_range(0, 1) == 0) begin
            // wrong second frame byte
            send_byte(frame_b ^ 8'($urandom_range(1, 255)), CHK_MODEL, NO_RESULT);
        end else if (!hdr_ok) begin
            // wrong header checksum
            send_byte(frame_b, CHK_MODEL, NO_RESULT);
            send_byte(len[7:0], CHK_MODEL, NO_RESULT);
            send_byte(hsum ^ 8'($urandom_range(1, 255)), CHK_MODEL, NO_RESULT);
        end else begin
            send_byte(frame_b, CHK_MODEL, NO_RESULT);
            send_byte(len[7:0], CHK_MODEL, NO_RESULT);
            send_byte(hsum, CHK_MODEL, NO_RESULT);
            send_byte(crc_b, CHK_MODEL, NO_RESULT);
            for (int i = 0; i < len; i++) begin
                if (i == retune_at) begin
                    wait_drained();
                    write_reg(CFG_MAX_BODY, retune_val);
                end
                send_byte(body[i], CHK_MODEL, NO_RESULT);
            end
        end
    endtask

    // Set the registers while idle, then mix packets, broken headers, noise and hang-ups
    task automatic run_phase(input logic [7:0] a, input logic [7:0] b, input logic [7:0] lim,
                             input bit idle, input int budget);
        int         stop_at;
        int         pick;
        int         len;
        int         bad_at;
        logic [7:0] v;
        wait_drained();
        write_reg(CFG_FRAME_FIRST, a);
        write_reg(CFG_FRAME_SECOND, b);
        write_reg(CFG_MAX_BODY, lim);
        idle_on = idle;
        stop_at = sent_count + budget;
        while (sent_count < stop_at) begin
            pick = $urandom_range(0, 9);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
            if (pick < 6) begin
                send_packet(len, $urandom_range(0, 3) != 0, 1'b1, -1, 8'h00);
            end else if (pick < 7) begin
                send_packet(len, 1'b1, 1'b0, -1, 8'h00);
            end else if (pick < 9) begin
                repeat ($urandom_range(1, 4)) begin
                    send_byte(8'($urandom_range(0, 255)), CHK_MODEL, NO_RESULT);
                end
            end else begin
                bad_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : -1;
                for (int i = 0; i < 14; i++) begin
                    v = HANGUP_SEQ[i];
                    if (i == bad_at) v = v ^ 8'($urandom_range(1, 255));
                    send_byte(v, CHK_MODEL, NO_RESULT);
                end
            end
        end
    endtask

    // Receiver: stall on a pattern (open, random or comb) that is picked anew at random
    always @(negedge i_clk) begin
        if (rx_span == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 2));
            rx_span = $urandom_range(20, 80);
        end
        rx_span = rx_span - 1;
        rx_tick = rx_tick + 8'd1;
        case (rx_mode)
            RX_OPEN:   i_m_axis_tready <= 1'b1;
            RX_RANDOM: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            default:   i_m_axis_tready <= (rx_tick[2:0] > 3'd2);
        endcase
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.kind       = t_kind'(o_m_axis_tuser);
            got.body_byte  = o_m_axis_tdata[7:0];
            got.end_status = t_status'(o_m_axis_tdata[9:8]);
            got.last       = o_m_axis_tlast;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none", $time);
                $display("%0t: got kind %0d byte %h status %0d last %b",
                         $time, got.kind, got.body_byte, got.end_status, got.last);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.kind != want.kind || got.body_byte != want.body_byte ||
                    got.end_status != want.end_status || got.last != want.last ||
                    o_m_axis_tdata[15:10] != 6'd0) begin
                    $display("%0t: result mismatch, expected kind %0d byte %h status %0d %s",
                             $time, want.kind, want.body_byte, want.end_status,
                             $sformatf("last %b pad 00", want.last));
                    $display("%0t: got kind %0d byte %h status %0d last %b pad %h",
                             $time, got.kind, got.body_byte, got.end_status, got.last,
                             o_m_axis_tdata[15:10]);
                    err_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'h00;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_FRAME_FIRST;
        i_cfg_data      = 8'h00;
        frame_a         = FRAME_FIRST_RST;
        frame_b         = FRAME_SECOND_RST;
        body_limit      = MAX_BODY_RST;
        hdr_count       = 0;
        pkt_len         = '0;
        pkt_crc         = '0;
        crc_run         = '0;
        hangup_pos      = '0;

        // Directed rows, run with the reset register values
        // wrong second frame byte
        add_row(8'h00, CHK_MODEL, KIND_BODY, ST_GOOD);
        add_row(8'hff, CHK_MODEL, KIND_BODY, ST_GOOD);
        // bad header checksum; the failing zero byte must not start a new hunt
        add_row(8'h00, CHK_MODEL, KIND_BODY, ST_GOOD);
        add_row(8'h00, CHK_MODEL, KIND_BODY, ST_GOOD);
        add_row(8'h05, CHK_MODEL, KIND_BODY, ST_GOOD);
        add_row(8'h00, CHK_MODEL, KIND_BODY, ST_GOOD);
        // empty body ends on the CRC byte with good status
        repeat (4) add_row(8'h00, CHK_MODEL, KIND_BODY, ST_GOOD);
        add_row(8'h00, CHK_TYPED, KIND_END, ST_GOOD);
        // fourteen-byte body that is the hang-up pattern: the last byte yields three results
        add_row(8'h00, CHK_MODEL, KIND_BODY, ST_GOOD);
        add_row(8'h00, CHK_MODEL, KIND_BODY, ST_GOOD);
        add_row(8'h0e, CHK_MODEL, KIND_BODY, ST_GOOD);
        add_row(8'h0e, CHK_MODEL, KIND_BODY, ST_GOOD);
        add_row(8'h00, CHK_MODEL, KIND_BODY, ST_GOOD);
        for (int i = 0; i < 14; i++) add_row(HANGUP_SEQ[i], CHK_MODEL, KIND_BODY, ST_GOOD);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].mode, dir_rows[i].want);

        // Random phases across register extremes
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'hff, 1'b1, 20);
        run_phase(8'hff, 8'h00, 8'h00, 1'b1, 20);
        run_phase(8'h00, 8'hff, 8'($urandom_range(2, 8)), 1'b1, 20);
        // drain mid-body and lower the limit before the rest of the body
        wait_drained();
        write_reg(CFG_MAX_BODY, 8'hff);
        send_packet(10, 1'b1, 1'b1, 4, 8'h03);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'b0, 20);
        run_phase(8'h0d, 8'h0a, 8'd20, 1'b1, 20);

        wait_drained();
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
src/spd_pkg.sv
src/serial_packet_deframer_core.sv
bench/serial_packet_deframer_core_tb.sv
